// ----- design/assert_macros.svh -----
// assertion macros shared by the decoder rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/bmp2rgb_pkg.sv -----
// shared types and constants for the bmp to rgb565 stream decoder
// no dependencies; imported by every decoder module
package bmp2rgb_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PIXEL      = 2'd0,
    KIND_HEADER_OK  = 2'd1,
    KIND_NOT_BMP    = 2'd2,
    KIND_BAD_FORMAT = 2'd3
  } kind_t;

  // parser phases, one-hot
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_t;

  // header byte positions
  localparam logic [23:0] POS_B    = 24'd0;
  localparam logic [23:0] POS_M    = 24'd1;
  localparam logic [23:0] POS_OFS0 = 24'd10;
  localparam logic [23:0] POS_OFS1 = 24'd11;
  localparam logic [23:0] POS_OFS2 = 24'd12;
  localparam logic [23:0] POS_OFS3 = 24'd13;
  localparam logic [23:0] POS_W0   = 24'd18;
  localparam logic [23:0] POS_W1   = 24'd19;
  localparam logic [23:0] POS_W2   = 24'd20;
  localparam logic [23:0] POS_W3   = 24'd21;
  localparam logic [23:0] POS_H0   = 24'd22;
  localparam logic [23:0] POS_H1   = 24'd23;
  localparam logic [23:0] POS_H2   = 24'd24;
  localparam logic [23:0] POS_H3   = 24'd25;
  localparam logic [23:0] POS_D0   = 24'd28;
  localparam logic [23:0] POS_D1   = 24'd29;

  localparam logic [7:0]  CHAR_B   = 8'h42;
  localparam logic [7:0]  CHAR_M   = 8'h4d;
  localparam logic [15:0] DEPTH_16 = 16'd16;
  localparam logic [15:0] DEPTH_24 = 16'd24;

  // rgb565 field masks
  localparam logic [15:0] MASK_BLUE  = 16'h001f;
  localparam logic [15:0] MASK_GREEN = 16'h07e0;
  localparam logic [15:0] MASK_RED   = 16'hf800;

  // command queue depth
  localparam int QDEPTH = 2;

  // command from front to back
  typedef struct packed {
    kind_t       kind;
    logic        is24;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [15:0] col;
    logic [15:0] src;
    logic [15:0] width;
    logic [15:0] height;
    logic        done;
  } cmd_t;

endpackage

// ----- design/bmp2rgb_front.sv -----
// front end: accepts file bytes, parses the header and tracks pixel position
// depends on bmp2rgb_pkg; pushes one command per result into the queue
module bmp2rgb_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tlast,
  input  logic               q_full,
  output logic               q_push,
  output bmp2rgb_pkg::cmd_t  q_cmd
);
  import bmp2rgb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  phase_t        phase_r, phase_nxt;
  logic [23:0]   pos_r, pos_nxt;
  logic [23:0]   offset_r, offset_nxt;
  logic [15:0]   width_r, width_nxt;
  logic [15:0]   height_r, height_nxt;
  logic          is24_r, is24_nxt;
  logic          size_bad_r, size_bad_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] src_r, src_nxt;
  logic [1:0]    bip_r, bip_nxt;
  logic [15:0]   held_r, held_nxt;
  logic [1:0]    pad_r, pad_nxt;

  logic          acc;
  logic          pix_fire;
  logic [7:0]    pb0, pb1, pb2;
  logic [15:0]   depth;
  logic          hdr_bad;
  logic [CW-1:0] col_inc;
  logic [RW-1:0] src_inc;
  logic          done;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign depth     = {in_tdata, held_r[7:0]};
  assign hdr_bad   = (depth != DEPTH_16 && depth != DEPTH_24) || size_bad_r ||
                     (width_r > 16'(MAX_WIDTH)) || (height_r > 16'(MAX_HEIGHT));
  assign col_inc   = col_r + CW'(1);
  assign src_inc   = src_r + RW'(1);
  assign done      = (16'(col_inc) == width_r) && (16'(src_inc) == height_r);

  // next-state and command build
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    offset_nxt   = offset_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    is24_nxt     = is24_r;
    size_bad_nxt = size_bad_r;
    col_nxt      = col_r;
    src_nxt      = src_r;
    bip_nxt      = bip_r;
    held_nxt     = held_r;
    pad_nxt      = pad_r;
    pix_fire     = 1'b0;
    pb0          = 8'h00;
    pb1          = 8'h00;
    pb2          = 8'h00;
    q_push       = 1'b0;
    q_cmd        = '0;
    q_cmd.kind   = KIND_PIXEL;

    if (acc) begin
      unique case (phase_r)
        PH_HEADER: begin
          priority if (pos_r == POS_B) begin
            held_nxt     = {8'h00, in_tdata};
            offset_nxt   = '0;
            width_nxt    = '0;
            height_nxt   = '0;
            size_bad_nxt = 1'b0;
          end else if (pos_r == POS_M) begin
            if (held_r != {8'h00, CHAR_B} || in_tdata != CHAR_M) begin
              q_push     = 1'b1;
              q_cmd.kind = KIND_NOT_BMP;
              phase_nxt  = PH_IDLE;
            end
          end else if (pos_r == POS_OFS0) begin
            offset_nxt[7:0] = in_tdata;
          end else if (pos_r == POS_OFS1) begin
            offset_nxt[15:8] = in_tdata;
          end else if (pos_r == POS_OFS2) begin
            offset_nxt[23:16] = in_tdata;
          end else if (pos_r == POS_W0) begin
            width_nxt[7:0] = in_tdata;
          end else if (pos_r == POS_W1) begin
            width_nxt[15:8] = in_tdata;
          end else if (pos_r == POS_H0) begin
            height_nxt[7:0] = in_tdata;
          end else if (pos_r == POS_H1) begin
            height_nxt[15:8] = in_tdata;
          end else if (pos_r == POS_OFS3 || pos_r == POS_W2 || pos_r == POS_W3 ||
                       pos_r == POS_H2 || pos_r == POS_H3) begin
            if (in_tdata != 8'h00) size_bad_nxt = 1'b1;
          end else if (pos_r == POS_D0) begin
            held_nxt = {8'h00, in_tdata};
          end else if (pos_r == POS_D1) begin
            q_push = 1'b1;
            if (hdr_bad) begin
              q_cmd.kind = KIND_BAD_FORMAT;
              phase_nxt  = PH_IDLE;
            end else begin
              q_cmd.kind   = KIND_HEADER_OK;
              q_cmd.width  = width_r;
              q_cmd.height = height_r;
              is24_nxt     = (depth == DEPTH_24);
              col_nxt      = '0;
              src_nxt      = '0;
              bip_nxt      = '0;
              held_nxt     = '0;
              pad_nxt      = '0;
              phase_nxt    = (width_r == 16'd0 || height_r == 16'd0) ? PH_IDLE : PH_DATA;
            end
          end else begin
            // remaining header bytes carry nothing the decoder uses
          end
          pos_nxt = pos_r + 24'd1;
        end
        PH_DATA: begin
          if (pos_r < offset_r) begin
            pos_nxt = pos_r + 24'd1;
          end else if (is24_r) begin
            if (bip_r == 2'd0) begin
              held_nxt = {8'h00, in_tdata};
              bip_nxt  = 2'd1;
            end else if (bip_r == 2'd1) begin
              held_nxt = {in_tdata, held_r[7:0]};
              bip_nxt  = 2'd2;
            end else begin
              bip_nxt  = 2'd0;
              pix_fire = 1'b1;
              pb0      = held_r[7:0];
              pb1      = held_r[15:8];
              pb2      = in_tdata;
            end
          end else begin
            if (bip_r == 2'd0) begin
              held_nxt = {8'h00, in_tdata};
              bip_nxt  = 2'd1;
            end else begin
              bip_nxt  = 2'd0;
              pix_fire = 1'b1;
              pb0      = held_r[7:0];
              pb1      = in_tdata;
            end
          end
        end
        PH_PAD: begin
          if (pad_r != 2'd0) pad_nxt = pad_r - 2'd1;
          if (pad_r <= 2'd1) phase_nxt = PH_DATA;
        end
        PH_IDLE: begin
        end
        default: begin
        end
      endcase

      // pixel result and column/row advance
      if (pix_fire) begin
        q_push       = 1'b1;
        q_cmd.kind   = KIND_PIXEL;
        q_cmd.is24   = is24_r;
        q_cmd.b0     = pb0;
        q_cmd.b1     = pb1;
        q_cmd.b2     = pb2;
        q_cmd.col    = 16'(col_r);
        q_cmd.src    = 16'(src_r);
        q_cmd.height = height_r;
        q_cmd.done   = done;
        col_nxt      = col_inc;
        if (16'(col_inc) >= width_r) begin
          col_nxt = '0;
          src_nxt = src_inc;
          if (!done && is24_r && width_r[1:0] != 2'd0) begin
            pad_nxt   = width_r[1:0];
            phase_nxt = PH_PAD;
          end
        end
        if (done) phase_nxt = PH_IDLE;
      end

      // end of file returns to header start
      if (in_tlast) begin
        phase_nxt = PH_HEADER;
        pos_nxt   = '0;
        col_nxt   = '0;
        src_nxt   = '0;
        bip_nxt   = '0;
        held_nxt  = '0;
        pad_nxt   = '0;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pos_r      <= '0;
      offset_r   <= '0;
      width_r    <= '0;
      height_r   <= '0;
      is24_r     <= 1'b0;
      size_bad_r <= 1'b0;
      col_r      <= '0;
      src_r      <= '0;
      bip_r      <= '0;
      held_r     <= '0;
      pad_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      offset_r   <= offset_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      is24_r     <= is24_nxt;
      size_bad_r <= size_bad_nxt;
      col_r      <= col_nxt;
      src_r      <= src_nxt;
      bip_r      <= bip_nxt;
      held_r     <= held_nxt;
      pad_r      <= pad_nxt;
    end
  end

endmodule

// ----- design/bmp2rgb_fifo.sv -----
// two-entry command queue between parser front and output back end
// depends on bmp2rgb_pkg for the command type and depth
module bmp2rgb_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bmp2rgb_pkg::cmd_t  cmd_in,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output bmp2rgb_pkg::cmd_t  cmd_out
);
  import bmp2rgb_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  cmd_t          mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == NW'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = mem_r[rd_ptr_r];

  // pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (do_push && !do_pop)      count_nxt = count_r + NW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= cmd_in;
  end

endmodule

// ----- design/bmp2rgb_back.sv -----
// back end: packs pixels to rgb565, flips rows and holds the output beat
// depends on bmp2rgb_pkg; pops commands from the queue
module bmp2rgb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  bmp2rgb_pkg::cmd_t  q_cmd,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [63:0]        out_tdata,
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);
  import bmp2rgb_pkg::*;

  logic        valid_r, valid_nxt;
  logic [63:0] data_r;
  logic [1:0]  user_r;
  logic        last_r;

  logic [15:0] pix24, pix16, pix;
  logic [15:0] row;
  logic [63:0] data_nxt;

  assign q_pop = !q_empty && (!valid_r || out_tready);

  // pixel packing and destination row
  assign pix24 = (({8'h00, q_cmd.b0} >> 3) & MASK_BLUE) |
                 (({8'h00, q_cmd.b1} << 3) & MASK_GREEN) |
                 (({8'h00, q_cmd.b2} << 8) & MASK_RED);
  assign pix16 = {q_cmd.b1, q_cmd.b0};
  assign pix   = q_cmd.is24 ? pix24 : pix16;
  assign row   = q_cmd.height - 16'd1 - q_cmd.src;

  // output beat fields by kind
  always_comb begin
    data_nxt = '0;
    unique case (q_cmd.kind)
      KIND_PIXEL: begin
        data_nxt[15:0]  = pix;
        data_nxt[26:16] = q_cmd.col[10:0];
        data_nxt[37:27] = row[10:0];
      end
      KIND_HEADER_OK: begin
        data_nxt[49:38] = q_cmd.width[11:0];
        data_nxt[61:50] = q_cmd.height[11:0];
      end
      KIND_NOT_BMP, KIND_BAD_FORMAT: begin
      end
      default: begin
      end
    endcase
  end

  assign valid_nxt = q_pop ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= data_nxt;
      user_r <= q_cmd.kind;
      last_r <= (q_cmd.kind == KIND_PIXEL) && q_cmd.done;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

// ----- design/bmp_to_rgb565_stream_decoder.sv -----
// bmp to rgb565 stream decoder, top level
// one file byte accepted per cycle while the queue is not full; the front registers position and counters per byte
// a result beat appears at out_tvalid once the byte that causes it has passed
// the queue entry, then the output register; sustained rate is one byte per cycle while out_tready is high
// reset: synchronous active-low rst_n; parser returns to header start, queue and output empty
// depends on bmp2rgb_pkg, bmp2rgb_front, bmp2rgb_fifo, bmp2rgb_back, assert_macros.svh
`include "assert_macros.svh"

module bmp_to_rgb565_stream_decoder #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // file_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] pixel_565, [26:16] pixel_column,
                                  // [37:27] pixel_row, [49:38] image_width,
                                  // [61:50] image_height, [63:62] zero
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  output logic        out_tlast   // image_done
);
  import bmp2rgb_pkg::*;

  logic q_full, q_push, q_pop, q_empty;
  cmd_t push_cmd, head_cmd;

  // parser front
  bmp2rgb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // command queue
  bmp2rgb_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .cmd_in  (push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .cmd_out (head_cmd)
  );

  // pixel back end
  bmp2rgb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // checks on result beats
  `ASSERT_IMPLY(a_last_is_pixel, clk, rst_n, out_tvalid && out_tlast, out_tuser == KIND_PIXEL)
  `ASSERT_IMPLY(a_nonpixel_clean, clk, rst_n, out_tvalid && out_tuser != KIND_PIXEL, out_tdata[37:0] == 38'd0)
  `ASSERT_IMPLY(a_pixel_no_size, clk, rst_n, out_tvalid && out_tuser == KIND_PIXEL, out_tdata[63:38] == 26'd0)
  `ASSERT_NEXT(a_queue_drains, clk, rst_n, q_full && !out_tvalid, out_tvalid)

endmodule
